// ----- rtl/core/wfc_pkg.sv -----
// ----------------------------------------------------------------------------
// wfc_pkg
// shared widths, reset value and cell control type for the width cap block
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int BUDGET_W = 22;
  localparam int CAP_W    = 24;
  localparam int COUNT_W  = 7;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 22'd65535;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/wfc_if.sv -----
// ----------------------------------------------------------------------------
// wfc interfaces
// valid/ready channels for widths in, cap results out and the budget write
// ----------------------------------------------------------------------------
interface wfc_in_if #(
  parameter int WIDTH_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] width;
  logic                  last;

  modport source (output valid, output width, output last, input ready);
  modport sink   (input valid, input width, input last, output ready);
endinterface

interface wfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [wfc_pkg::CAP_W-1:0]    cap_q8;
  logic                         limited;
  logic [wfc_pkg::COUNT_W-1:0]  capped_count;

  modport source (output valid, output cap_q8, output limited, output capped_count,
                  input ready);
  modport sink   (input valid, input cap_q8, input limited, input capped_count,
                  output ready);
endinterface

interface wfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wfc_pkg::BUDGET_W-1:0]  width_budget;

  modport source (output valid, output width_budget, input ready);
  modport sink   (input valid, input width_budget, output ready);
endinterface

// ----- rtl/core/wfc_cell.sv -----
// ----------------------------------------------------------------------------
// wfc_cell
// one slot of the sorted row: takes part in insertion and shifts toward slot 0
// ----------------------------------------------------------------------------
module wfc_cell #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                  clk,
  input  wfc_pkg::cell_ctrl_t   ctrl,
  input  logic                  occ,
  input  logic                  left_occ,
  input  logic [WIDTH_BITS-1:0] left_val,
  input  logic [WIDTH_BITS-1:0] right_val,
  input  logic [WIDTH_BITS-1:0] ins_w,
  output logic [WIDTH_BITS-1:0] val
);

  logic [WIDTH_BITS-1:0] val_r;
  logic                  keep;
  logic                  take_left;

  assign keep      = occ && (val_r >= ins_w);
  assign take_left = left_occ && (left_val < ins_w);

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      val_r <= right_val;
    end else if (ctrl.ins_en && !keep) begin
      val_r <= take_left ? left_val : ins_w;
    end
  end

  assign val = val_r;

endmodule

// ----- rtl/core/wfc_div.sv -----
// ----------------------------------------------------------------------------
// wfc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wfc_div #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/water_filling_width_cap.sv -----
// ----------------------------------------------------------------------------
// water_filling_width_cap
// max-min fair cap over a set of widths held in a sorted row of cells
// ----------------------------------------------------------------------------
//  channel  dir  fields                              word
//  in_ch    in   width, last                         one element
//  out_ch   out  cap_q8, limited, capped_count       one result per set
//  cfg_ch   in   width_budget                        budget write
//
//  loading: one element per cycle while in the load state, insertion across the
//    cell row in one step
//  end of set: walk (one row shift per step), divider, then a register to the output
//  reset: synchronous; no clearing pass, the row holds data only up to the fill count
//  a result stalled at the output holds the next set at the end of its divide
// ----------------------------------------------------------------------------
module water_filling_width_cap #(
  parameter int MAX_ITEMS  = 64,
  parameter int WIDTH_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  wfc_in_if.sink    in_ch,
  wfc_out_if.source out_ch,
  wfc_cfg_if.sink   cfg_ch
);

  localparam int BW    = wfc_pkg::BUDGET_W;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int TW    = WIDTH_BITS + CNT_W;
  localparam int SW    = (TW > BW) ? TW : BW;
  localparam int DW    = BW + FRAC_BITS;
  localparam int CAPW0 = ((WIDTH_BITS + FRAC_BITS > DW) ? WIDTH_BITS + FRAC_BITS : DW) + 1;
  localparam int CAPW  = (CAPW0 > wfc_pkg::CAP_W) ? CAPW0 : wfc_pkg::CAP_W;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [BW-1:0]         budget_r;
  logic [CNT_W-1:0]      count_r;
  logic [TW-1:0]         total_r;
  logic [CNT_W-1:0]      n_r;
  logic [CNT_W-1:0]      idx_r;
  logic [TW-1:0]         sum_r;
  logic                  limited_r;
  logic [WIDTH_BITS-1:0] cur_r;

  logic                  out_valid_r;
  logic [wfc_pkg::CAP_W-1:0]   cap_r;
  logic                  out_lim_r;
  logic [wfc_pkg::COUNT_W-1:0] out_cnt_r;

  logic                  in_acc;
  logic                  room;
  logic                  ins;
  logic [CNT_W-1:0]      count_after;
  logic [TW-1:0]         total_after;
  logic                  cur_ok;
  logic                  nxt_ok;
  logic                  step;
  logic [WIDTH_BITS-1:0] nxt_w;
  logic [WIDTH_BITS-1:0] diff;
  logic [TW-1:0]         prod;
  logic [CNT_W-1:0]      idx_inc;
  logic                  div_start;
  logic                  div_busy;
  logic [DW-1:0]         div_q;
  logic [SW-1:0]         slack;
  logic                  finish;
  logic [CAPW-1:0]       cap_full;

  wfc_pkg::cell_ctrl_t   ctrl;
  logic [WIDTH_BITS-1:0] cv [0:MAX_ITEMS];
  logic [MAX_ITEMS:0]    occ_ext;

  // handshakes
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_LOAD);
  assign cfg_ch.ready = 1'b1;

  assign room        = count_r < CNT_W'(MAX_ITEMS);
  assign ins         = in_acc && room;
  assign count_after = ins ? count_r + 1'b1 : count_r;
  assign total_after = ins ? total_r + TW'(in_ch.width) : total_r;

  // walk down the sorted row
  assign cur_ok  = idx_r < n_r;
  assign nxt_ok  = ((CNT_W + 1)'(idx_r) + 1'b1) < (CNT_W + 1)'(n_r);
  assign step    = (state_r == ST_WALK) && cur_ok && (SW'(sum_r) > SW'(budget_r));
  assign nxt_w   = nxt_ok ? cv[1] : '0;
  assign diff    = cv[0] - nxt_w;
  assign idx_inc = idx_r + 1'b1;
  assign prod    = TW'(TW'(diff) * TW'(idx_inc));

  assign div_start = (state_r == ST_WALK) && !step;
  assign slack     = SW'(budget_r) - SW'(sum_r);
  assign finish    = (state_r == ST_DIV) && !div_busy && (!out_valid_r || out_ch.ready);
  assign cap_full  = (CAPW'(cur_r) << FRAC_BITS)
                   + ((idx_r == '0) ? '0 : CAPW'(div_q));

  assign ctrl.ins_en   = ins;
  assign ctrl.shift_en = step;

  // cell row
  assign cv[MAX_ITEMS] = '0;
  assign occ_ext[0]    = 1'b0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    logic [WIDTH_BITS-1:0] lv;
    assign occ_ext[g+1] = count_r > CNT_W'(g);
    if (g == 0) begin : g_first
      assign lv = '0;
    end else begin : g_rest
      assign lv = cv[g-1];
    end
    wfc_cell #(
      .WIDTH_BITS(WIDTH_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ_ext[g+1]),
      .left_occ (occ_ext[g]),
      .left_val (lv),
      .right_val(cv[g+1]),
      .ins_w    (in_ch.width),
      .val      (cv[g])
    );
  end

  wfc_div #(
    .DVD_W(DW),
    .DVS_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(DW'(slack[BW-1:0]) << FRAC_BITS),
    .divisor (idx_r),
    .busy    (div_busy),
    .quotient(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!step) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (finish) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      budget_r    <= wfc_pkg::BUDGET_RESET;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        budget_r <= cfg_ch.width_budget;
      end
      if (in_acc) begin
        if (in_ch.last) begin
          count_r <= '0;
          total_r <= '0;
        end else begin
          count_r <= count_after;
          total_r <= total_after;
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and result words
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last) begin
      n_r       <= count_after;
      sum_r     <= total_after;
      idx_r     <= '0;
      limited_r <= SW'(total_after) > SW'(budget_r);
    end else if (step) begin
      sum_r <= sum_r - prod;
      idx_r <= idx_inc;
    end
    if (div_start) begin
      cur_r <= cur_ok ? cv[0] : '0;
    end
    if (finish) begin
      cap_r     <= cap_full[wfc_pkg::CAP_W-1:0];
      out_lim_r <= limited_r;
      out_cnt_r <= wfc_pkg::COUNT_W'(idx_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cap_q8       = cap_r;
  assign out_ch.limited      = out_lim_r;
  assign out_ch.capped_count = out_cnt_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond row length");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> idx_r <= n_r)
    else $error("walk index beyond set size");

  a_last_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last |=> state_r == ST_WALK)
    else $error("last word did not start the walk");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_busy) |-> $past(state_r) == ST_WALK)
    else $error("divider started outside the walk");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !ctrl.ins_en)
    else $error("insertion while a set is being resolved");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for water_filling_width_cap
// drives sets of widths and budget writes, predicts (or takes from the plan) the fair cap
// of each set and checks every result word in order; directed rows first, then random sets
// under several idle and stall mixes
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_ITEMS     = 64;
  localparam int WIDTH_BITS    = 16;
  localparam int FRAC_BITS     = 8;
  localparam int BUDGET_W      = wfc_pkg::BUDGET_W;
  localparam int CAP_W         = wfc_pkg::CAP_W;
  localparam int COUNT_W       = wfc_pkg::COUNT_W;
  localparam int SETTLE_CYCLES = 2 * (MAX_ITEMS + 1 + BUDGET_W + FRAC_BITS + 4);
  localparam int RANDOM_ITEMS  = 1130;
  localparam int PHASE_ITEMS   = 100;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PLAN_ROWS     = 24;

  typedef struct packed {
    logic [CAP_W-1:0]   cap_q8;
    logic               limited;
    logic [COUNT_W-1:0] capped_count;
  } cap_result_t;

  typedef enum logic {ROW_BUDGET, ROW_WIDTH} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [BUDGET_W-1:0] value;
    logic               last;
    logic               typed;
    logic [CAP_W-1:0]   cap_q8;
    logic               limited;
    logic [COUNT_W-1:0] capped_count;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  wfc_in_if #(.WIDTH_BITS(WIDTH_BITS)) in_ch ();
  wfc_out_if out_ch ();
  wfc_cfg_if cfg_ch ();

  water_filling_width_cap #(
    .MAX_ITEMS (MAX_ITEMS),
    .WIDTH_BITS(WIDTH_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [WIDTH_BITS-1:0] row_widths [MAX_ITEMS];
  int                    row_fill;
  longint unsigned       row_total;
  longint unsigned       budget_now;

  cap_result_t pending_caps [$];
  int          fail_count = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          cycle_count = 0;

  plan_row_t plan_rows [0:PLAN_ROWS-1] = '{
    '{ROW_WIDTH,  22'd100,     1'b1, 1'b1, 24'd25600,    1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b1, 1'b1, 24'd16776960, 1'b0, 7'd0},
    '{ROW_WIDTH,  22'd0,       1'b1, 1'b1, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd1,       1'b1, 1'b1, 24'd16776704, 1'b1, 7'd1},
    '{ROW_BUDGET, 22'd0,       1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd0,       1'b1, 1'b1, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b1, 1'b1, 24'd0,        1'b1, 7'd1},
    '{ROW_WIDTH,  22'd5,       1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd7,       1'b1, 1'b1, 24'd0,        1'b1, 7'd2},
    '{ROW_BUDGET, 22'd4194303, 1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b1, 1'b1, 24'd16776960, 1'b0, 7'd0},
    '{ROW_BUDGET, 22'd1000,    1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd300,     1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd500,     1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd800,     1'b1, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd400,     1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd400,     1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd400,     1'b1, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_BUDGET, 22'd65535,   1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b0, 1'b0, 24'd0,        1'b0, 7'd0},
    '{ROW_WIDTH,  22'd65535,   1'b1, 1'b1, 24'd8388480,  1'b1, 7'd2}
  };

  // sorted insert of one width; on the last word, walk down to the fair cap
  function automatic bit fair_cap_of_word(input logic [WIDTH_BITS-1:0] w, input logic l,
                                          output cap_result_t res);
    int              pos;
    int              idx;
    longint unsigned level;
    longint unsigned below;
    longint unsigned sum;
    longint unsigned cap;
    res = '0;
    if (row_fill < MAX_ITEMS) begin
      pos = row_fill;
      while (pos > 0 && row_widths[pos-1] < w) begin
        row_widths[pos] = row_widths[pos-1];
        pos--;
      end
      row_widths[pos] = w;
      row_fill++;
      row_total += w;
    end
    if (!l) return 1'b0;
    idx = 0;
    sum = row_total;
    while (idx < row_fill && sum > budget_now) begin
      level = row_widths[idx];
      below = (idx + 1 < row_fill) ? row_widths[idx+1] : 0;
      sum   = sum - (level - below) * longint'(idx + 1);
      idx++;
    end
    cap = (idx < row_fill) ? row_widths[idx] : 0;
    cap = cap << FRAC_BITS;
    if (idx > 0) cap += ((budget_now - sum) << FRAC_BITS) / longint'(idx);
    res.cap_q8       = cap[CAP_W-1:0];
    res.limited      = (row_total > budget_now);
    res.capped_count = idx[COUNT_W-1:0];
    row_fill  = 0;
    row_total = 0;
    return 1'b1;
  endfunction

  task automatic send_width(input logic [WIDTH_BITS-1:0] w, input logic l,
                            input bit typed, input cap_result_t typed_res);
    cap_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.width <= w;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
    if (fair_cap_of_word(w, l, res)) pending_caps = {pending_caps, typed ? typed_res : res};
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_caps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] b);
    settle();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.width_budget <= b;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    budget_now = b;
  endtask

  always @(posedge clk) begin : result_check
    cap_result_t got;
    cap_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.cap_q8, out_ch.limited, out_ch.capped_count};
      if (pending_caps.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result word: cap %0d limited %0d count %0d",
                   got.cap_q8, got.limited, got.capped_count);
        fail_count++;
      end else begin
        want = pending_caps.pop_front();
        if (got != want) begin
          if (fail_count < 10)
            $display(
              "mismatch: expected cap %0d limited %0d count %0d, got %0d %0d %0d",
              want.cap_q8, want.limited, want.capped_count,
              got.cap_q8, got.limited, got.capped_count);
          fail_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    cap_result_t     typed_res;
    plan_row_t       pr;
    int              sent;
    int              phase_sent;
    int              phase;
    int              set_len;
    int              pick;
    logic [BUDGET_W-1:0]   b;
    logic [WIDTH_BITS-1:0] w;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    row_fill       = 0;
    row_total      = 0;
    budget_now     = wfc_pkg::BUDGET_RESET;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.width         <= '0;
    in_ch.last          <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.width_budget <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < PLAN_ROWS; i++) begin
      pr = plan_rows[i];
      if (pr.kind == ROW_BUDGET) begin
        write_budget(pr.value);
      end else begin
        typed_res = {pr.cap_q8, pr.limited, pr.capped_count};
        send_width(pr.value[WIDTH_BITS-1:0], pr.last, pr.typed, typed_res);
      end
    end

    // random sets, one budget and one idle mix per phase
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 6)
        0:       b = '0;
        1:       b = '1;
        2:       b = BUDGET_W'($urandom_range(0, 2000));
        3:       b = BUDGET_W'($urandom_range(0, 300000));
        4:       b = BUDGET_W'($urandom_range(0, 4194303));
        default: b = wfc_pkg::BUDGET_RESET;
      endcase
      write_budget(b);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (phase_sent == 0 && phase % 3 == 1) set_len = $urandom_range(MAX_ITEMS + 1, 72);
        else if (pick < 70) set_len = $urandom_range(1, 8);
        else if (pick < 88) set_len = $urandom_range(9, 40);
        else if (pick < 96) set_len = $urandom_range(41, MAX_ITEMS);
        else set_len = $urandom_range(MAX_ITEMS + 1, 72);
        for (int k = 0; k < set_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) w = '0;
          else if (pick < 20) w = '1;
          else if (pick < 50) w = WIDTH_BITS'($urandom_range(0, 255));
          else w = WIDTH_BITS'($urandom_range(0, 65535));
          send_width(w, k == set_len - 1, 1'b0, '0);
          if (k < MAX_ITEMS) phase_sent++;
        end
      end
      sent += phase_sent;
      phase++;
    end

    settle();
    if (fail_count == 0 && pending_caps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
